// ===== rtl/psgwd_pkg.sv =====
// shared types and constants for the sound chip write decoder and mixer
package psgwd_pkg;

    localparam int NUM_W      = 24;
    localparam int DEN_W      = 10;
    localparam int DIV_STEPS  = NUM_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int TERM_W     = 21;
    localparam int SUM_W      = 23;
    localparam int VOLSUM_W   = 6;
    localparam int FREQ_W     = 17;

    localparam logic [16:0] MIX_CONST = 17'd125000;

    localparam logic [1:0] KIND_VOL  = 2'd0;
    localparam logic [1:0] KIND_FREQ = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] chan;
        logic [5:0] val;
        logic       en;
    } cmd_t;

endpackage

// ===== rtl/psg_write_decode_and_mix_unit.sv =====
// top level of the sound chip register write decoder and tone mixer
//
// input side is a queue: a byte on write_byte is taken when push is high and
// full is low. noise latch bytes are taken and dropped. every other byte is
// decoded into a request and held in a two-entry queue for the mixer
// result side is a queue too: while empty is low, tone_on and frequency_hz
// hold the oldest result, taken when pop is high
// cfg_write loads cfg_data into the sound enable bit; with it clear, bytes
// still update channel state but give no result
// the mixer applies a request, then checks each of channels 1 to 3 in turn;
// each such channel with nonzero period, and then the volume-weighted mean,
// go through one shared divider before the result goes to the output register
// a finished result waits in the mixer until the output register is empty or
// being popped, while the front keeps taking bytes until the queue fills
// reset clears all periods, volumes and the latched channel, empties both
// sides, and sets the sound enable bit
module psg_write_decode_and_mix_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       write_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic                             tone_on,
    output logic [psgwd_pkg::FREQ_W-1:0]     frequency_hz,
    input  logic                             cfg_write,
    input  logic                             cfg_data
);

    logic            cmd_push;
    psgwd_pkg::cmd_t cmd;
    psgwd_pkg::cmd_t q_data;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    psgwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .write_byte (write_byte),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .full       (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    psgwd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    psgwd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .tone_on      (tone_on),
        .frequency_hz (frequency_hz)
    );

endmodule

// ===== rtl/psgwd_front.sv =====
// front end: accepts written bytes, holds the enable register, classifies requests
module psgwd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        write_byte,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  logic              q_full,
    output logic              full,
    output logic              cmd_push,
    output psgwd_pkg::cmd_t   cmd
);

    logic enable_reg;
    logic noise;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            enable_reg <= cfg_data;
        end
    end

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign noise    = (write_byte[7:5] == 3'b111);
    assign cmd_push = accept && !noise;

    always_comb
    begin
        cmd.en   = enable_reg;
        cmd.chan = 2'd3 - write_byte[6:5];
        if (write_byte[7] && write_byte[4])
        begin
            cmd.kind = psgwd_pkg::KIND_VOL;
            cmd.val  = {2'b00, 4'd15 - write_byte[3:0]};
        end
        else if (write_byte[7])
        begin
            cmd.kind = psgwd_pkg::KIND_FREQ;
            cmd.val  = {2'b00, write_byte[3:0]};
        end
        else
        begin
            cmd.kind = psgwd_pkg::KIND_DATA;
            cmd.val  = write_byte[5:0];
        end
    end

endmodule

// ===== rtl/psgwd_queue.sv =====
// two-entry request queue between front end and mixer
module psgwd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  psgwd_pkg::cmd_t   wr_data,
    input  logic              rd_en,
    output psgwd_pkg::cmd_t   rd_data,
    output logic              q_full,
    output logic              q_empty
);

    psgwd_pkg::cmd_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/psgwd_div.sv =====
// iterative restoring divider, two quotient bits per cycle
module psgwd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [psgwd_pkg::NUM_W-1:0]   num,
    input  logic [psgwd_pkg::DEN_W-1:0]   den,
    output logic                          done,
    output logic [psgwd_pkg::NUM_W-1:0]   quo
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [psgwd_pkg::CNT_W-1:0]   cnt_reg;
    logic [psgwd_pkg::DEN_W-1:0]   rem_reg;
    logic [psgwd_pkg::DEN_W-1:0]   den_reg;
    logic [psgwd_pkg::NUM_W-1:0]   quo_reg;
    logic [psgwd_pkg::DEN_W-1:0]   rem_next;
    logic [psgwd_pkg::NUM_W-1:0]   quo_next;

    always_comb
    begin
        logic [psgwd_pkg::DEN_W:0]   t;
        logic [psgwd_pkg::DEN_W-1:0] r;
        logic [psgwd_pkg::NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, q[psgwd_pkg::NUM_W-1]};
            q = {q[psgwd_pkg::NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t    = t - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = t[psgwd_pkg::DEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= psgwd_pkg::CNT_W'(psgwd_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - psgwd_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/psgwd_back.sv =====
// back end: applies requests to channel state, mixes the tones, holds the result
module psgwd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  psgwd_pkg::cmd_t                  q_data,
    output logic                             q_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic                             tone_on,
    output logic [psgwd_pkg::FREQ_W-1:0]     frequency_hz
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TERM  = 3'd1;
    localparam logic [2:0] S_TWAIT = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_FWAIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                          state_reg;
    logic [9:0]                          period_reg [4];
    logic [3:0]                          volume_reg [4];
    logic [1:0]                          latched_reg;
    logic                                lvalid_reg;
    logic [1:0]                          ch_reg;
    logic [psgwd_pkg::SUM_W-1:0]         sum_reg;
    logic                                res_tone_reg;
    logic [psgwd_pkg::FREQ_W-1:0]        res_freq_reg;
    logic                                out_valid_reg;
    logic                                out_tone_reg;
    logic [psgwd_pkg::FREQ_W-1:0]        out_freq_reg;

    logic                                div_start;
    logic [psgwd_pkg::NUM_W-1:0]         div_num;
    logic [psgwd_pkg::DEN_W-1:0]         div_den;
    logic                                div_done;
    logic [psgwd_pkg::NUM_W-1:0]         div_quo;
    logic [psgwd_pkg::VOLSUM_W-1:0]      totvol;
    logic [psgwd_pkg::TERM_W-1:0]        product;
    logic                                out_load;

    assign totvol = {2'b00, volume_reg[1]} + {2'b00, volume_reg[2]}
                  + {2'b00, volume_reg[3]};
    assign product = psgwd_pkg::TERM_W'(volume_reg[ch_reg]) * psgwd_pkg::MIX_CONST;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || pop);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = {{(psgwd_pkg::NUM_W - psgwd_pkg::TERM_W){1'b0}}, product};
        div_den   = period_reg[ch_reg];
        if (state_reg == S_TERM)
        begin
            div_start = (period_reg[ch_reg] != 10'd0);
        end
        else if (state_reg == S_FINAL)
        begin
            div_start = (totvol != '0);
            div_num   = {{(psgwd_pkg::NUM_W - psgwd_pkg::SUM_W){1'b0}}, sum_reg};
            div_den   = {{(psgwd_pkg::DEN_W - psgwd_pkg::VOLSUM_W){1'b0}}, totvol};
        end
    end

    psgwd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            latched_reg  <= 2'd0;
            lvalid_reg   <= 1'b0;
            ch_reg       <= 2'd1;
            sum_reg      <= '0;
            res_tone_reg <= 1'b0;
            res_freq_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                period_reg[i] <= 10'd0;
                volume_reg[i] <= 4'd0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        case (q_data.kind)
                            psgwd_pkg::KIND_VOL:
                            begin
                                volume_reg[q_data.chan] <= q_data.val[3:0];
                            end
                            psgwd_pkg::KIND_FREQ:
                            begin
                                period_reg[q_data.chan] <= {6'd0, q_data.val[3:0]};
                                latched_reg             <= q_data.chan;
                                lvalid_reg              <= 1'b1;
                            end
                            psgwd_pkg::KIND_DATA:
                            begin
                                if (lvalid_reg)
                                begin
                                    period_reg[latched_reg][9:4] <= q_data.val;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        ch_reg  <= 2'd1;
                        sum_reg <= '0;
                        if (q_data.en)
                        begin
                            state_reg <= S_TERM;
                        end
                    end
                end
                S_TERM:
                begin
                    if (period_reg[ch_reg] != 10'd0)
                    begin
                        state_reg <= S_TWAIT;
                    end
                    else if (ch_reg == 2'd3)
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_TWAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg <= sum_reg + {{(psgwd_pkg::SUM_W - psgwd_pkg::TERM_W){1'b0}},
                                              div_quo[psgwd_pkg::TERM_W-1:0]};
                        if (ch_reg == 2'd3)
                        begin
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_TERM;
                        end
                    end
                end
                S_FINAL:
                begin
                    if (totvol == '0)
                    begin
                        res_tone_reg <= 1'b0;
                        res_freq_reg <= '0;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_FWAIT;
                    end
                end
                S_FWAIT:
                begin
                    if (div_done)
                    begin
                        res_tone_reg <= 1'b1;
                        res_freq_reg <= div_quo[psgwd_pkg::FREQ_W-1:0];
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_tone_reg <= res_tone_reg;
            out_freq_reg <= res_freq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign tone_on      = out_tone_reg;
    assign frequency_hz = out_freq_reg;

endmodule

// ===== bench/psg_write_decode_and_mix_unit_tb.sv =====
// testbench for the sound chip write decoder and tone mixer, checked against a scoreboard
`timescale 1ns / 100ps

module psg_write_decode_and_mix_unit_tb;

    localparam int FREQ_BITS     = psgwd_pkg::FREQ_W;
    localparam int unsigned TONE_BASE_HZ = 125000;
    localparam logic [7:0] NOISE_MASK = 8'hE0;
    localparam logic [7:0] VOL_MASK   = 8'h90;
    localparam logic [7:0] LATCH_BIT  = 8'h80;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic                 tone;
        logic [FREQ_BITS-1:0] freq;
    } mix_result_t;

    class mix_scoreboard;
        logic [9:0]  period [4];
        logic [3:0]  volume [4];
        logic [1:0]  latched;
        logic        latched_ok;
        logic        enabled;
        mix_result_t mix_expected [$];
        int          mismatches;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                period[i] = '0;
                volume[i] = '0;
            end
            latched    = '0;
            latched_ok = 1'b0;
            enabled    = 1'b1;
            mismatches = 0;
        endfunction

        function void set_enable(logic v);
            enabled = v;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [1:0]  c;
            int unsigned tot;
            int unsigned sum;
            mix_result_t r;
            if ((b & NOISE_MASK) == NOISE_MASK)
                return;
            c = 2'd3 - b[6:5];
            if ((b & VOL_MASK) == VOL_MASK)
                volume[c] = 4'hF - b[3:0];
            else if ((b & LATCH_BIT) != 0)
            begin
                period[c]  = {6'b0, b[3:0]};
                latched    = c;
                latched_ok = 1'b1;
            end
            else if (latched_ok)
                period[latched][9:4] = b[5:0];
            if (!enabled)
                return;
            tot = 0;
            sum = 0;
            for (int i = 1; i < 4; i++)
            begin
                tot += volume[i];
                if (period[i] != 0)
                    sum += (32'(volume[i]) * TONE_BASE_HZ) / 32'(period[i]);
            end
            if (tot == 0)
            begin
                r.tone = 1'b0;
                r.freq = '0;
            end
            else
            begin
                r.tone = 1'b1;
                r.freq = FREQ_BITS'(sum / tot);
            end
            mix_expected.push_back(r);
        endfunction

        function void check_result(logic tone, logic [FREQ_BITS-1:0] freq);
            mix_result_t e;
            if (mix_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: tone_on=%0b frequency_hz=%0d", tone, freq);
                return;
            end
            e = mix_expected.pop_front();
            if (tone !== e.tone || freq !== e.freq)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected tone_on=%0b frequency_hz=%0d, got %0b %0d",
                             e.tone, e.freq, tone, freq);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           write_byte = 8'h00;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 tone_on;
    logic [FREQ_BITS-1:0] frequency_hz;
    logic                 cfg_write = 1'b0;
    logic                 cfg_data = 1'b0;

    mix_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_start = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    bit  data_due = 1'b0;

    psg_write_decode_and_mix_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .write_byte   (write_byte),
        .empty        (empty),
        .pop          (pop),
        .tone_on      (tone_on),
        .frequency_hz (frequency_hz),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // receiver side
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_byte(write_byte);
            if (pop && !empty)
                sb.check_result(tone_on, frequency_hz);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        write_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.mix_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(logic v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_enable(v);
    endtask

    function automatic logic [3:0] weighted_nibble(int zero_pct);
        if ($urandom_range(99) < zero_pct)
            return 4'h0;
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [7:0] next_byte();
        int r;
        logic [1:0] ch;
        r  = $urandom_range(99);
        ch = 2'($urandom_range(2));
        if (data_due && r < 85)
        begin
            data_due = 1'b0;
            return {1'b0, 1'($urandom_range(1)),
                    ($urandom_range(99) < 15) ? 6'd0 : 6'($urandom_range(63))};
        end
        data_due = 1'b0;
        if (r < 10)
            return {3'b111, 5'($urandom_range(31))};
        if (r < 20)
            return 8'($urandom_range(255));
        if (r < 60)
        begin
            data_due = 1'b1;
            return {1'b1, ch, 1'b0, weighted_nibble(15)};
        end
        return {1'b1, ch, 1'b1, ~weighted_nibble(30)};
    endfunction

    task automatic run_phase(logic en, int sidle, int rstall, int count, int hold_at);
        int sent;
        logic [7:0] b;
        wait_drained();
        write_enable(en);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        sent = 0;
        while (sent < count)
        begin
            if (sent == hold_at)
                hold_start = 1'b1;
            b = next_byte();
            send_byte(b);
            if ((b & NOISE_MASK) != NOISE_MASK)
                sent++;
        end
    endtask

    logic [7:0] directed [$] = '{
        8'h00, 8'h7F, 8'hE0, 8'hFF, 8'h90, 8'hBF, 8'hD5, 8'h80, 8'h3F, 8'h8F,
        8'h7F, 8'hA1, 8'hB0, 8'hC0, 8'h40, 8'hCF, 8'h01, 8'hD0, 8'h9F, 8'hBF,
        8'hDF, 8'hB0, 8'h90, 8'hA1, 8'h00
    };

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_byte(directed[i]);
        run_phase(1'b1, 0, 0, 300, -1);
        run_phase(1'b1, 50, 0, 300, -1);
        run_phase(1'b0, 0, 50, 200, -1);
        run_phase(1'b1, 0, 50, 300, 50);
        run_phase(1'b0, 19, 19, 200, -1);
        run_phase(1'b1, 19, 19, 250, 120);
        run_phase(1'b1, 0, 0, 250, -1);
        wait_drained();
        if (sb.mix_expected.size() != 0)
            $display("%0d expected results never arrived", sb.mix_expected.size());
        if (sb.mismatches == 0 && sb.mix_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
